/* design/catmull_rom_closed_curve_eval_core_defines.svh */
// assertion macros for the catmull-rom curve core
`ifndef CATMULL_ROM_CLOSED_CURVE_EVAL_CORE_DEFINES_SVH
`define CATMULL_ROM_CLOSED_CURVE_EVAL_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/crc_eval_pkg.sv */
// shared types, codes and fixed-point helpers of the catmull-rom curve core
`default_nettype none

package crc_eval_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned AccW   = 40;
  localparam int unsigned TW     = 16;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } crc_cmd_t;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [AccW-1:0]   acc_t;

  // stage enables handed to each coordinate lane
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } crc_pipe_en_t;

  // floor((x * t + 2^15) / 2^16)
  function automatic acc_t mul_round(input acc_t x, input logic [TW-1:0] t);
    logic signed [AccW+TW:0]   prod;
    logic signed [AccW+TW+1:0] sum;
    logic signed [AccW+TW+1:0] shf;
    begin
      prod = x * $signed({1'b0, t});
      sum  = {prod[AccW+TW], prod} + (AccW+TW+2)'(32768);
      shf  = sum >>> TW;
      return shf[AccW-1:0];
    end
  endfunction

  // floor((x + 1) / 2) saturated to signed 32 bits
  function automatic coord_t sat_half(input acc_t x);
    logic signed [AccW:0] h;
    begin
      h = ($signed({x[AccW-1], x}) + (AccW+1)'(1)) >>> 1;
      if (h > (AccW+1)'(64'sh7fff_ffff)) return 32'sh7fff_ffff;
      else if (h < -(AccW+1)'(64'sh8000_0000)) return 32'sh8000_0000;
      else return h[CoordW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* design/crc_eval_lane.sv */
// one coordinate of the curve datapath: basis terms, horner steps, saturation
`default_nettype none

module crc_eval_lane (
  input  wire logic                        clk,
  input  wire crc_eval_pkg::crc_pipe_en_t  en,
  input  wire crc_eval_pkg::coord_t        p0,
  input  wire crc_eval_pkg::coord_t        p1,
  input  wire crc_eval_pkg::coord_t        p2,
  input  wire crc_eval_pkg::coord_t        p3,
  input  wire logic [15:0]                 t_in,
  output crc_eval_pkg::coord_t             pos,
  output crc_eval_pkg::coord_t             tan
);
  import crc_eval_pkg::*;

  acc_t q0, q1, q2, q3;
  acc_t b0_r, b1_r, b2_r, b3_r;
  acc_t a1_r, d1_r, b2_4_r, b3_4_r;
  acc_t a2_r, d2_r, b3_5_r;
  acc_t a3_r, d3_r;
  logic [TW-1:0] t3_r, t4_r, t5_r;
  coord_t pos_r, tan_r;

  assign q0 = AccW'(p0);
  assign q1 = AccW'(p1);
  assign q2 = AccW'(p2);
  assign q3 = AccW'(p3);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      b0_r <= q3 - q0 + AccW'(3) * q1 - AccW'(3) * q2;
      b1_r <= AccW'(2) * q0 - AccW'(5) * q1 + AccW'(4) * q2 - q3;
      b2_r <= q2 - q0;
      b3_r <= AccW'(2) * q1;
      t3_r <= t_in;
    end
    if (en.s4) begin
      a1_r   <= mul_round(b0_r, t3_r) + b1_r;
      d1_r   <= mul_round(AccW'(3) * b0_r, t3_r) + AccW'(2) * b1_r;
      b2_4_r <= b2_r;
      b3_4_r <= b3_r;
      t4_r   <= t3_r;
    end
    if (en.s5) begin
      a2_r   <= mul_round(a1_r, t4_r) + b2_4_r;
      d2_r   <= mul_round(d1_r, t4_r) + b2_4_r;
      b3_5_r <= b3_4_r;
      t5_r   <= t4_r;
    end
    if (en.s6) begin
      a3_r <= mul_round(a2_r, t5_r) + b3_5_r;
      d3_r <= d2_r;
    end
    if (en.s7) begin
      pos_r <= sat_half(a3_r);
      tan_r <= sat_half(d3_r);
    end
  end

  assign pos = pos_r;
  assign tan = tan_r;

endmodule

`default_nettype wire

/* design/catmull_rom_closed_curve_eval_core.sv */
// top level of the closed uniform catmull-rom curve evaluator
`default_nettype none
`include "catmull_rom_closed_curve_eval_core_defines.svh"

// closed catmull-rom curve core: a load transaction (tuser = 0) stores one q16.16
// point at point_index, an evaluate transaction (tuser = 1) turns a q0.16
// parameter into position and derivative by local t, both saturated q16.16.
// throughput is one transaction per cycle while the output is not stalled; an
// evaluate result is valid on the output once it has passed the store read,
// basis, horner and saturation registers. the four points of a segment
// come from four copies of the point store, each with one write and one read
// port, so all four reads happen in the same cycle. loads write the store in
// the same pipeline stage that evaluates read it, so order is kept. stalls ripple
// back stage by stage; empty stages keep filling while a result waits. num_points
// must be written only while idle; the block does not enforce it. values below 4
// act as 4, above MAX_POINTS as MAX_POINTS. never-loaded slots read as garbage.
module catmull_rom_closed_curve_eval_core #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [5:0] point_index, [37:6] coord_x, [69:38] coord_y, [101:70] coord_z,
  // [117:102] curve_param, [119:118] zero
  input  wire logic [119:0] in_tdata,
  // [0] cmd
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z,
  // [127:96] tan_x, [159:128] tan_y, [191:160] tan_z
  output logic [191:0]      out_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [6:0]   cfg_wr_data
);
  import crc_eval_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned IW = (AW > 7) ? AW : 7;

  // control
  logic [6:0] num_points_r;
  logic [7:1] vld_r;
  logic [7:1] rdy;

  // stage 1 payload
  crc_cmd_t    cmd1_r;
  logic [6:0]  seg1_r;
  logic [6:0]  n1_r;
  logic [15:0] t1_r;
  logic [5:0]  pidx1_r;
  logic [95:0] pt1_r;

  // stage 2 payload
  logic [15:0] t2_r;
  logic [95:0] rd_r [4];

  logic [6:0]  n_eff;
  logic [22:0] scaled;
  logic [6:0]  idx0, idx2, idx3;
  logic [6:0]  seg_inc;
  logic [IW-1:0] rd_idx [4];
  logic [IW-1:0] wr_idx;
  logic        wr_en;
  crc_pipe_en_t pen;
  coord_t      pos_c [3];
  coord_t      tan_c [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= 7'd4;
    end else if (cfg_wr_en) begin
      num_points_r <= cfg_wr_data;
    end
  end

  // ready ripples back: a stage takes new data when empty or when it drains
  always_comb begin
    rdy[7] = !vld_r[7] || out_tready;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end
  assign in_tready = rdy[1];

  // clamp the point count and scale the parameter
  always_comb begin
    if (num_points_r < 7'd4) n_eff = 7'd4;
    else if (32'(num_points_r) > MAX_POINTS) n_eff = 7'(MAX_POINTS);
    else n_eff = num_points_r;
  end
  assign scaled = 23'(in_tdata[117:102]) * 23'(n_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) vld_r[1] <= in_tvalid;
      // loads retire at the store write and leave no result
      if (rdy[2]) vld_r[2] <= vld_r[1] && (cmd1_r == CMD_EVAL);
      for (int k = 3; k <= 7; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      cmd1_r  <= crc_cmd_t'(in_tuser);
      seg1_r  <= scaled[22:16];
      t1_r    <= scaled[15:0];
      n1_r    <= n_eff;
      pidx1_r <= in_tdata[5:0];
      pt1_r   <= in_tdata[101:6];
    end
  end

  // wraparound neighbors of the segment
  always_comb begin
    seg_inc = seg1_r + 7'd1;
    idx0    = (seg1_r == 7'd0) ? (n1_r - 7'd1) : (seg1_r - 7'd1);
    idx2    = (seg_inc == n1_r) ? 7'd0 : seg_inc;
    idx3    = ((idx2 + 7'd1) == n1_r) ? 7'd0 : (idx2 + 7'd1);
    rd_idx[0] = IW'(idx0);
    rd_idx[1] = IW'(seg1_r);
    rd_idx[2] = IW'(idx2);
    rd_idx[3] = IW'(idx3);
    wr_idx    = IW'(pidx1_r);
  end

  assign wr_en = rdy[2] && vld_r[1] && (cmd1_r == CMD_LOAD) && (32'(pidx1_r) < MAX_POINTS);

  // four copies of the point store, one per gathered point
  for (genvar g = 0; g < 4; g++) begin : g_store
    logic [95:0] mem [MAX_POINTS];

    always_ff @(posedge clk) begin
      if (wr_en) mem[wr_idx[AW-1:0]] <= pt1_r;
    end

    always_ff @(posedge clk) begin
      if (rdy[2]) rd_r[g] <= mem[rd_idx[g][AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) t2_r <= t1_r;
  end

  assign pen.s3 = rdy[3];
  assign pen.s4 = rdy[4];
  assign pen.s5 = rdy[5];
  assign pen.s6 = rdy[6];
  assign pen.s7 = rdy[7];

  // x, y, z lanes
  for (genvar c = 0; c < 3; c++) begin : g_lane
    crc_eval_lane u_lane (
      .clk  (clk),
      .en   (pen),
      .p0   (rd_r[0][32*c +: 32]),
      .p1   (rd_r[1][32*c +: 32]),
      .p2   (rd_r[2][32*c +: 32]),
      .p3   (rd_r[3][32*c +: 32]),
      .t_in (t2_r),
      .pos  (pos_c[c]),
      .tan  (tan_c[c])
    );
  end

  assign out_tvalid = vld_r[7];
  assign out_tdata  = {tan_c[2], tan_c[1], tan_c[0], pos_c[2], pos_c[1], pos_c[0]};

  // an accepted evaluate occupies stage 1 next cycle
  `CRC_ASSERT_NEXT(a_eval_enters, in_tvalid && in_tready && in_tuser, vld_r[1], "eval lost at entry")
  // a load never turns into a result
  `CRC_ASSERT_NEXT(a_load_drops, vld_r[1] && (cmd1_r == CMD_LOAD) && rdy[2], !vld_r[2], "load made result")
  // a blocked stage keeps its transaction
  `CRC_ASSERT_NEXT(a_stage_hold, vld_r[6] && !rdy[6], vld_r[6] && vld_r[7], "stage 6 lost data")

endmodule

`default_nettype wire
